// ----- rtl/core/midi_chord_event_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// MIDI chord event encoder assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MIDI_CHORD_EVENT_ENCODER_MACROS_SVH
`define MIDI_CHORD_EVENT_ENCODER_MACROS_SVH

// same-cycle implication
`define MCEE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MCEE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/mcee_pkg.sv -----
// ----------------------------------------------------------------------------
// mcee_pkg
// Shared types and constants of the MIDI chord event encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mcee_pkg;

   localparam int KEY_W   = 7;
   localparam int VEL_W   = 7;
   localparam int DUR_W   = 24;
   localparam int DELTA_W = DUR_W + 2;

   localparam int MAX_CHORD_NOTES_DEF = 12;

   localparam logic [7:0]       STATUS_ON      = 8'h90;
   localparam logic [7:0]       STATUS_OFF     = 8'h80;
   localparam logic [KEY_W-1:0] KEY_MIDDLE_C   = 7'd60;
   localparam logic [KEY_W-1:0] KEY_OFFSET     = 7'd33;
   localparam logic [VEL_W-1:0] ACCENT_STEP    = 7'd16;
   localparam logic [VEL_W-1:0] VEL_MAX        = 7'h7f;
   localparam logic [VEL_W-1:0] BASE_VEL_RESET = 7'd100;

   typedef enum logic [2:0] {
      ACT_ADD    = 3'd0,
      ACT_PLAY   = 3'd1,
      ACT_REST   = 3'd2,
      ACT_SINGLE = 3'd3,
      ACT_BAR    = 3'd4
   } action_type;

   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [2:0] len;
   } vlq_type;

   localparam vlq_type VLQ_ZERO = '{b0: 8'h00, b1: 8'h00, b2: 8'h00, b3: 8'h00,
                                    len: 3'd1};

   typedef struct packed {
      vlq_type          dly;
      logic [7:0]       status;
      logic [KEY_W-1:0] key;
      logic [VEL_W-1:0] vel;
      logic             last;
   } evt_type;

endpackage

`default_nettype wire

// ----- rtl/core/mcee_req_if.sv -----
// ----------------------------------------------------------------------------
// mcee_req_if
// Action channel: valid/ready with one tablature action per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcee_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [6:0]  tab_pitch;
   logic [6:0]  midi_key;
   logic [23:0] duration;

   modport source (output valid, output action, output tab_pitch, output midi_key,
                   output duration, input ready);
   modport sink   (input valid, input action, input tab_pitch, input midi_key,
                   input duration, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mcee_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mcee_rsp_if
// Event channel: valid/ready with one MIDI channel event per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcee_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] delta_byte0;
   logic [7:0] delta_byte1;
   logic [7:0] delta_byte2;
   logic [7:0] delta_byte3;
   logic [2:0] delta_len;
   logic [7:0] status;
   logic [6:0] event_key;
   logic [6:0] event_velocity;
   logic       last;

   modport source (output valid, output delta_byte0, output delta_byte1,
                   output delta_byte2, output delta_byte3, output delta_len,
                   output status, output event_key, output event_velocity,
                   output last, input ready);
   modport sink   (input valid, input delta_byte0, input delta_byte1,
                   input delta_byte2, input delta_byte3, input delta_len,
                   input status, input event_key, input event_velocity,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mcee_key_store.sv -----
// ----------------------------------------------------------------------------
// mcee_key_store
// Chord key memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcee_key_store
   import mcee_pkg::*;
#(
   parameter int MAX_CHORD_NOTES = MAX_CHORD_NOTES_DEF,
   localparam int IDX_W = (MAX_CHORD_NOTES > 1) ? $clog2(MAX_CHORD_NOTES) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [KEY_W-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output logic      [KEY_W-1:0] rd_data
);

   logic [KEY_W-1:0] keys_ff [MAX_CHORD_NOTES];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         keys_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= keys_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mcee_vlq.sv -----
// ----------------------------------------------------------------------------
// mcee_vlq
// Delta time encoder: duration times three as a MIDI variable-length quantity.
// ----------------------------------------------------------------------------
`default_nettype none

module mcee_vlq
   import mcee_pkg::*;
(
   input  wire logic [DUR_W-1:0] duration,
   output vlq_type               code
);

   logic [DELTA_W-1:0] delta;
   logic [6:0]         g0;
   logic [6:0]         g1;
   logic [6:0]         g2;
   logic [6:0]         g3;

   assign delta = {2'b00, duration} + {1'b0, duration, 1'b0};
   assign g0    = delta[6:0];
   assign g1    = delta[13:7];
   assign g2    = delta[20:14];
   assign g3    = {2'b00, delta[25:21]};

   always_comb begin
      code = VLQ_ZERO;
      if (g3 != '0) begin
         code = '{b0: {1'b1, g3}, b1: {1'b1, g2}, b2: {1'b1, g1}, b3: {1'b0, g0},
                  len: 3'd4};
      end else if (g2 != '0) begin
         code = '{b0: {1'b1, g2}, b1: {1'b1, g1}, b2: {1'b0, g0}, b3: 8'h00,
                  len: 3'd3};
      end else if (g1 != '0) begin
         code = '{b0: {1'b1, g1}, b1: {1'b0, g0}, b2: 8'h00, b3: 8'h00,
                  len: 3'd2};
      end else begin
         code = '{b0: {1'b0, g0}, b1: 8'h00, b2: 8'h00, b3: 8'h00, len: 3'd1};
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/mcee_seq.sv -----
// ----------------------------------------------------------------------------
// mcee_seq
// Action decoder and event sequencer; walks the key memory for chord plays.
// ----------------------------------------------------------------------------
`default_nettype none

module mcee_seq
   import mcee_pkg::*;
#(
   parameter int MAX_CHORD_NOTES = MAX_CHORD_NOTES_DEF,
   localparam int IDX_W = (MAX_CHORD_NOTES > 1) ? $clog2(MAX_CHORD_NOTES) : 1,
   localparam int CNT_W = $clog2(MAX_CHORD_NOTES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [VEL_W-1:0] base_vel,
   mcee_req_if.sink              req_ch,
   mcee_rsp_if.source            rsp_ch,
   output logic                  wr_en,
   output logic      [IDX_W-1:0] wr_addr,
   output logic      [KEY_W-1:0] wr_data,
   output logic                  rd_en,
   output logic      [IDX_W-1:0] rd_addr,
   input  wire logic [KEY_W-1:0] rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ON,
      S_OFF,
      S_PAIR_ON,
      S_PAIR_OFF
   } state_type;

   state_type        state_ff,    state_in;
   logic [CNT_W-1:0] count_ff,    count_in;
   logic [CNT_W-1:0] num_ff,      num_in;
   logic [IDX_W-1:0] idx_ff,      idx_in;
   logic             accent_ff,   accent_in;
   logic [VEL_W-1:0] on_vel_ff,   on_vel_in;
   logic [KEY_W-1:0] pair_key_ff, pair_key_in;
   vlq_type          dly_ff,      dly_in;
   logic             rsp_valid_ff, rsp_valid_in;
   evt_type          evt_ff,      evt_in;

   vlq_type          vlq_code;
   logic             accept;
   logic             slot_free;
   logic             idx_last;
   logic [VEL_W:0]   acc_sum;
   logic [VEL_W-1:0] take_vel;

   mcee_vlq u_vlq (
      .duration (req_ch.duration),
      .code     (vlq_code)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && (state_ff == S_IDLE);
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign idx_last     = (CNT_W'(idx_ff) + CNT_W'(1)) == num_ff;
   assign acc_sum      = {1'b0, base_vel} + {1'b0, ACCENT_STEP};
   assign take_vel     = !accent_ff ? base_vel :
                         (acc_sum > {1'b0, VEL_MAX}) ? VEL_MAX : acc_sum[VEL_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      num_in       = num_ff;
      idx_in       = idx_ff;
      accent_in    = accent_ff;
      on_vel_in    = on_vel_ff;
      pair_key_in  = pair_key_ff;
      dly_in       = dly_ff;
      evt_in       = evt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = req_ch.tab_pitch + KEY_OFFSET;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dly_in = vlq_code;
               unique case (action_type'(req_ch.action))
                  ACT_ADD: begin
                     if (count_ff < CNT_W'(MAX_CHORD_NOTES)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_PLAY: begin
                     on_vel_in = take_vel;
                     accent_in = 1'b0;
                     num_in    = count_ff;
                     count_in  = '0;
                     idx_in    = '0;
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        state_in = S_ON;
                     end
                  end
                  ACT_REST: begin
                     count_in    = '0;
                     pair_key_in = KEY_MIDDLE_C;
                     on_vel_in   = '0;
                     state_in    = S_PAIR_ON;
                  end
                  ACT_SINGLE: begin
                     on_vel_in   = take_vel;
                     accent_in   = 1'b0;
                     pair_key_in = req_ch.midi_key;
                     state_in    = S_PAIR_ON;
                  end
                  ACT_BAR: begin
                     accent_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ON: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               evt_in       = '{dly: VLQ_ZERO, status: STATUS_ON, key: rd_data,
                                vel: on_vel_ff, last: 1'b0};
               rd_en        = 1'b1;
               if (idx_last) begin
                  idx_in   = '0;
                  rd_addr  = '0;
                  state_in = S_OFF;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         S_OFF: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               evt_in       = '{dly: (idx_ff == '0) ? dly_ff : VLQ_ZERO,
                                status: STATUS_OFF, key: rd_data, vel: base_vel,
                                last: idx_last};
               if (idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         S_PAIR_ON: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               evt_in       = '{dly: VLQ_ZERO, status: STATUS_ON, key: pair_key_ff,
                                vel: on_vel_ff, last: 1'b0};
               state_in     = S_PAIR_OFF;
            end
         end
         S_PAIR_OFF: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               evt_in       = '{dly: dly_ff, status: STATUS_OFF, key: pair_key_ff,
                                vel: base_vel, last: 1'b1};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         accent_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         accent_ff    <= accent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff      <= num_in;
      idx_ff      <= idx_in;
      on_vel_ff   <= on_vel_in;
      pair_key_ff <= pair_key_in;
      dly_ff      <= dly_in;
      evt_ff      <= evt_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.delta_byte0    = evt_ff.dly.b0;
   assign rsp_ch.delta_byte1    = evt_ff.dly.b1;
   assign rsp_ch.delta_byte2    = evt_ff.dly.b2;
   assign rsp_ch.delta_byte3    = evt_ff.dly.b3;
   assign rsp_ch.delta_len      = evt_ff.dly.len;
   assign rsp_ch.status         = evt_ff.status;
   assign rsp_ch.event_key      = evt_ff.key;
   assign rsp_ch.event_velocity = evt_ff.vel;
   assign rsp_ch.last           = evt_ff.last;

endmodule

`default_nettype wire

// ----- rtl/core/midi_chord_event_encoder.sv -----
// ----------------------------------------------------------------------------
// midi_chord_event_encoder
// Tablature actions in, MIDI channel-0 note events with VLQ deltas out.
//
//   channel  dir  payload                                        beat
//   req_ch   in   action, tab_pitch, midi_key, duration          one action
//   rsp_ch   out  delta_byte0..3, delta_len, status, event_key,  one event
//                 event_velocity, last
//   csr      in   csr_we, csr_wdata (base velocity)              one write
//
// Add, bar mark and unused codes end at the accept. Rest and single note give
// a note-on and a note-off; a chord of N keys gives N note-ons, then N
// note-offs, one key memory read per event, the first issued at the accept.
// Reset (synchronous) empties the chord, drops the accent, sets velocity 100.
// A stall on rsp_ch holds the sequencer; the last event may wait in the
// output register while the next action is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_chord_event_encoder
   import mcee_pkg::*;
#(
   parameter int MAX_CHORD_NOTES = MAX_CHORD_NOTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   mcee_req_if.sink              req_ch,
   mcee_rsp_if.source            rsp_ch,
   input  wire logic             csr_we,
   input  wire logic [VEL_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_CHORD_NOTES > 1) ? $clog2(MAX_CHORD_NOTES) : 1;

   logic [VEL_W-1:0] base_vel_ff, base_vel_in;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [KEY_W-1:0] wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [KEY_W-1:0] rd_data;

   assign base_vel_in = csr_we ? csr_wdata : base_vel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_vel_ff <= BASE_VEL_RESET;
      end else begin
         base_vel_ff <= base_vel_in;
      end
   end

   mcee_key_store #(
      .MAX_CHORD_NOTES (MAX_CHORD_NOTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mcee_seq #(
      .MAX_CHORD_NOTES (MAX_CHORD_NOTES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .base_vel (base_vel_ff),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

endmodule

`default_nettype wire

// ----- rtl/core/mcee_checker.sv -----
// ----------------------------------------------------------------------------
// mcee_checker
// Port-level checks on the event channel, bound to the encoder top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_chord_event_encoder_macros.svh"

module mcee_checker
   import mcee_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_delta_byte0,
   input wire logic [2:0] rsp_delta_len,
   input wire logic [7:0] rsp_status,
   input wire logic [6:0] rsp_event_key,
   input wire logic       rsp_last
);

   `MCEE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_delta_byte0) && $stable(rsp_event_key) && $stable(rsp_status), "rsp beat dropped or changed under stall")
   `MCEE_ASSERT_NOW(a_rsp_status, rsp_valid, rsp_status == STATUS_ON || rsp_status == STATUS_OFF, "bad status byte")
   `MCEE_ASSERT_NOW(a_on_not_last, rsp_valid && rsp_status == STATUS_ON, !rsp_last, "note-on flagged last")
   `MCEE_ASSERT_NOW(a_len_range, rsp_valid, rsp_delta_len >= 3'd1 && rsp_delta_len <= 3'd4, "delta length out of range")

endmodule

bind midi_chord_event_encoder mcee_checker u_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_delta_byte0 (rsp_ch.delta_byte0),
   .rsp_delta_len   (rsp_ch.delta_len),
   .rsp_status      (rsp_ch.status),
   .rsp_event_key   (rsp_ch.event_key),
   .rsp_last        (rsp_ch.last)
);

`default_nettype wire
